/* hdl/crc_checked_frame_deframer_core_macros.svh */
// Assertion helpers shared by the deframer RTL.
`ifndef CRC_CHECKED_FRAME_DEFRAMER_CORE_MACROS_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define CCFD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed: same-cycle implication");

// Next-cycle implication, reset masks the check.
`define CCFD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed: next-cycle implication");

`endif

/* hdl/ccfd_pkg.sv */
`default_nettype none

package ccfd_pkg;

  // Frame delimiters and the present-flag mask
  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;
  localparam logic [7:0] TAIL_BYTE  = 8'hDD;
  localparam logic [7:0] PRESENT_MASK = 8'h01;

  // CRC16 XMODEM: poly 0x1021, init 0, no reflection
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  localparam int PAYLOAD_BYTES = 6;
  localparam int COUNT_W = 3;
  localparam logic [COUNT_W-1:0] LAST_INDEX = COUNT_W'(PAYLOAD_BYTES - 1);
  localparam logic [COUNT_W-1:0] STORE_DEPTH = COUNT_W'(PAYLOAD_BYTES);

  // Hunt state, one-hot
  typedef enum logic [4:0] {
    PH_WAIT_AA  = 5'b00001,
    PH_WAIT_55  = 5'b00010,
    PH_PAYLOAD  = 5'b00100,
    PH_CRC      = 5'b01000,
    PH_TAIL     = 5'b10000
  } phase_t;

  // One decoded frame
  typedef struct packed {
    logic               target_present;
    logic signed [7:0]  zone;
    logic        [15:0] center_x;
    logic        [15:0] center_y;
  } result_t;

  // One byte of the running CRC, MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/ccfd_byte_if.sv */
`default_nettype none

// Byte stream channel
interface ccfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* hdl/ccfd_result_if.sv */
`default_nettype none

// Decoded frame channel
interface ccfd_result_if;
  logic               valid;
  logic               ready;
  logic               target_present;
  logic signed [7:0]  zone;
  logic        [15:0] center_x;
  logic        [15:0] center_y;

  modport source (output valid, output target_present, output zone, output center_x,
                  output center_y, input ready);
  modport sink (input valid, input target_present, input zone, input center_x,
                input center_y, output ready);
endinterface

`default_nettype wire

/* hdl/ccfd_parser.sv */
`default_nettype none
`include "crc_checked_frame_deframer_core_macros.svh"

// Frame hunt, payload capture and running CRC. Advances one byte per step.
module ccfd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output logic              emit,
  output ccfd_pkg::result_t result
);
  import ccfd_pkg::*;

  phase_t              phase, phase_next;
  logic [7:0]          payload_store [PAYLOAD_BYTES];
  logic [COUNT_W-1:0]  payload_count, payload_count_next;
  logic [15:0]         running_crc, running_crc_next;
  logic                crc_low_seen, crc_low_seen_next;
  logic [15:0]         received_crc, received_crc_next;

  // Next-state decode for the current byte
  always_comb begin
    phase_next         = phase;
    payload_count_next = payload_count;
    running_crc_next   = running_crc;
    crc_low_seen_next  = crc_low_seen;
    received_crc_next  = received_crc;
    emit               = 1'b0;
    case (phase)
      PH_WAIT_55: begin
        if (rx_byte == HDR_SECOND) begin
          phase_next         = PH_PAYLOAD;
          payload_count_next = '0;
          running_crc_next   = CRC_INIT;
          crc_low_seen_next  = 1'b0;
        end else if (rx_byte == HDR_FIRST) begin
          phase_next = PH_WAIT_55;
        end else begin
          phase_next = PH_WAIT_AA;
        end
      end
      PH_PAYLOAD: begin
        running_crc_next   = crc16_step(running_crc, rx_byte);
        payload_count_next = payload_count + 1'b1;
        if (payload_count == LAST_INDEX) begin
          phase_next        = PH_CRC;
          crc_low_seen_next = 1'b0;
        end
      end
      PH_CRC: begin
        if (!crc_low_seen) begin
          received_crc_next = {8'h00, rx_byte};
          crc_low_seen_next = 1'b1;
        end else begin
          received_crc_next = {rx_byte, received_crc[7:0]};
          crc_low_seen_next = 1'b0;
          phase_next        = PH_TAIL;
        end
      end
      PH_TAIL: begin
        emit       = (rx_byte == TAIL_BYTE) && (running_crc == received_crc);
        phase_next = PH_WAIT_AA;
      end
      default: begin
        // waiting for AA; any stray code recovers here too
        phase_next = (rx_byte == HDR_FIRST) ? PH_WAIT_55 : PH_WAIT_AA;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT_AA;
      payload_count <= '0;
      running_crc   <= CRC_INIT;
      crc_low_seen  <= 1'b0;
      received_crc  <= '0;
    end else if (step) begin
      phase         <= phase_next;
      payload_count <= payload_count_next;
      running_crc   <= running_crc_next;
      crc_low_seen  <= crc_low_seen_next;
      received_crc  <= received_crc_next;
    end
  end

  // Payload capture, one entry per byte
  always_ff @(posedge clk) begin
    if (step && (phase == PH_PAYLOAD) && (payload_count < STORE_DEPTH)) begin
      payload_store[payload_count] <= rx_byte;
    end
  end

  // Field unpacking, little-endian words
  assign result.target_present = |(payload_store[0] & PRESENT_MASK);
  assign result.zone           = $signed(payload_store[1]);
  assign result.center_x       = {payload_store[3], payload_store[2]};
  assign result.center_y       = {payload_store[5], payload_store[4]};

  `CCFD_ASSERT_IMP(a_emit_only_at_tail, clk, rst, emit, phase == PH_TAIL)
  `CCFD_ASSERT_NXT(a_payload_ends, clk, rst,
                   step && (phase == PH_PAYLOAD) && (payload_count == LAST_INDEX),
                   phase == PH_CRC)
  `CCFD_ASSERT_NXT(a_frame_start_clears, clk, rst,
                   step && (phase == PH_WAIT_55) && (rx_byte == HDR_SECOND),
                   (payload_count == '0) && (running_crc == CRC_INIT) && !crc_low_seen)

endmodule

`default_nettype wire

/* hdl/crc_checked_frame_deframer_core.sv */
// CRC-checked frame deframer.
// rx carries one received byte per transfer (valid/ready). The core hunts for
// frames AA 55, six payload bytes, CRC16 XMODEM low byte then high byte, DD.
// frame carries one decoded result per good frame: present flag, signed zone,
// X and Y. Frames with a wrong tail or a CRC mismatch give no transfer.
// Throughput: one byte per cycle while no byte that gives a result waits on a
// stalled frame; the only loop is the per-byte CRC and hunt state update.
// A byte is taken into the input register and decoded there; a tail byte that
// completes a good frame loads the result register as it leaves the input
// register, and the result then shows on frame.
// Reset (rst, synchronous, active high) empties both registers and returns
// the hunt to waiting for AA; no clearing pass is needed.
// When the receiver stalls, the result is held and bytes that give no result
// keep flowing; a byte that would give a second result waits in the input
// register, and rx.ready drops until frame takes the pending result.
`default_nettype none
`include "crc_checked_frame_deframer_core_macros.svh"

module crc_checked_frame_deframer_core (
  input  logic clk,
  input  logic rst,
  ccfd_byte_if.sink     rx,
  ccfd_result_if.source frame
);
  import ccfd_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       res_valid;
  result_t    res;
  result_t    parsed;
  logic       emit;
  logic       advance;

  // Byte in the input register moves on unless it needs a busy result slot
  assign advance  = in_valid && (!emit || !res_valid || frame.ready);
  assign rx.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  ccfd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .emit    (emit),
    .result  (parsed)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && emit) begin
      res_valid <= 1'b1;
    end else if (frame.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res <= parsed;
    end
  end

  assign frame.valid          = res_valid;
  assign frame.target_present = res.target_present;
  assign frame.zone           = res.zone;
  assign frame.center_x       = res.center_x;
  assign frame.center_y       = res.center_y;

  `CCFD_ASSERT_NXT(a_held_byte_kept, clk, rst, in_valid && !advance,
                   in_valid && $stable(in_byte))
  `CCFD_ASSERT_NXT(a_result_loaded, clk, rst, advance && emit,
                   res_valid && (res == $past(parsed)))
  `CCFD_ASSERT_NXT(a_byte_captured, clk, rst, rx.valid && rx.ready,
                   in_valid && (in_byte == $past(rx.rx_byte)))

endmodule

`default_nettype wire
